@@ sv/ukl_pkg.sv @@
// ----------------------------------------------------------------------------
// ukl_pkg
// Shared constants, codes and types for the unordered key list.
// ----------------------------------------------------------------------------
package ukl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int ECNT_W   = 5;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_SEARCH = 2'd1;
    localparam func_t FUNC_DELETE = 2'd2;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_UNUSED    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } ukl_state_t;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  position;
        logic [ECNT_W-1:0] entry_count;
    } ukl_result_t;

endpackage

@@ sv/ukl_ram.sv @@
// ----------------------------------------------------------------------------
// ukl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ukl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ukl_engine.sv @@
// ----------------------------------------------------------------------------
// ukl_engine
// Sequencer: append, linear scan and shift-down delete over the key RAM.
// ----------------------------------------------------------------------------
module ukl_engine
    import ukl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  func_t       in_func,
    input  key_t        in_key,
    output logic        res_valid,
    input  logic        res_ready,
    output ukl_result_t res
);

    ukl_state_t  state_reg, state_next;
    func_t       func_reg, func_next;
    key_t        key_reg, key_next;
    idx_t        idx_reg, idx_next;
    cnt_t        count_reg, count_next;
    ukl_result_t res_reg, res_next;

    logic        wr_en;
    idx_t        wr_addr;
    key_t        wr_data;
    idx_t        rd_addr;
    key_t        rd_data;

    logic             accept;
    logic             match;
    cnt_t             idx_inc;
    logic [CNT_W:0]   shift_inc;
    logic             scan_more;
    logic             shift_more;
    logic             full;

    ukl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_keys (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_RESULT);
    assign res        = res_reg;
    assign accept     = in_valid && in_ready;
    assign match      = (rd_data == key_reg);
    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign shift_inc  = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(2);
    assign scan_more  = (idx_inc < count_reg);
    assign shift_more = (shift_inc < {1'b0, count_reg});
    assign full       = (count_reg >= CNT_W'(CAPACITY));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((in_func == FUNC_SEARCH || in_func == FUNC_DELETE)
                        && count_reg != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    state_next = (func_reg == FUNC_DELETE && scan_more) ? ST_SHIFT : ST_RESULT;
                end else begin
                    state_next = scan_more ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SHIFT: begin
                state_next = shift_more ? ST_SHIFT : ST_RESULT;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        func_next  = func_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        rd_addr    = IDX_W'(idx_inc);
        case (state_reg)
            ST_IDLE: begin
                rd_addr = '0;
                if (accept) begin
                    func_next            = in_func;
                    key_next             = in_key;
                    idx_next             = '0;
                    res_next.status      = STATUS_OK;
                    res_next.position    = '0;
                    res_next.entry_count = ECNT_W'(count_reg);
                    case (in_func)
                        FUNC_INSERT: begin
                            if (full) begin
                                res_next.status = STATUS_FULL;
                            end else begin
                                wr_en                = 1'b1;
                                wr_addr              = IDX_W'(count_reg);
                                wr_data              = in_key;
                                count_next           = count_reg + CNT_W'(1);
                                res_next.position    = POS_W'(count_reg);
                                res_next.entry_count = ECNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        FUNC_SEARCH, FUNC_DELETE: begin
                            if (count_reg == '0) begin
                                res_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    res_next.position = POS_W'(idx_reg);
                    if (func_reg == FUNC_DELETE && !scan_more) begin
                        count_next           = count_reg - CNT_W'(1);
                        res_next.entry_count = ECNT_W'(count_reg - CNT_W'(1));
                    end
                end else if (scan_more) begin
                    idx_next = IDX_W'(idx_inc);
                end else begin
                    res_next.status = STATUS_NOT_FOUND;
                end
            end
            ST_SHIFT: begin
                // rd_data holds entry idx+1; move it down one slot
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                rd_addr = IDX_W'(shift_inc);
                if (shift_more) begin
                    idx_next = IDX_W'(idx_inc);
                end else begin
                    count_next           = count_reg - CNT_W'(1);
                    res_next.entry_count = ECNT_W'(count_reg - CNT_W'(1));
                end
            end
            ST_RESULT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        key_reg  <= key_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
    end

endmodule

@@ sv/unordered_key_list.sv @@
// ----------------------------------------------------------------------------
// unordered_key_list
// Insertion-ordered list of signed 32-bit keys: append, search, delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser carries the function (insert, search,
//   delete first match), s_tdata the key. One result word per input word
//   leaves on m_*: m_tuser is the status, m_tdata the position and the
//   number of keys held afterwards.
//   Keys sit in a 16 x 32 RAM with registered read. Insert writes at the
//   tail. Search reads one entry per cycle from the head, then hands off
//   the result. Delete scans the same way, then moves each later entry
//   down one slot, one per cycle. The scan/shift loop runs over the single
//   read port of the RAM.
//   Results land in an output register; s_tready returns high as soon as
//   the result has moved there, so the next word is taken while that
//   result still waits for m_tready. A stalled receiver holds the output
//   register, which in turn holds the sequencer in its result state.
//   Reset (aresetn low, synchronous) empties the list and drops m_tvalid;
//   RAM contents are not cleared since only entries below the count are read.
// ----------------------------------------------------------------------------
module unordered_key_list
    import ukl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] position, [8:4] entry_count, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic        res_valid;
    logic        res_ready;
    ukl_result_t res;

    logic        m_tvalid_reg, m_tvalid_next;
    ukl_result_t m_res_reg, m_res_next;

    ukl_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_key    (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {7'd0, m_res_reg.entry_count, m_res_reg.position};

endmodule

@@ sv/ukl_checker.sv @@
// ----------------------------------------------------------------------------
// ukl_checker
// Port-level assertions for the unordered key list, bound to the top level.
// ----------------------------------------------------------------------------
module ukl_checker
    import ukl_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one word in flight in the sequencer: an accept always drops ready
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken back to back");

    // full is reported only with a full count
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_FULL |-> m_tdata[8:4] == ECNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    // no undefined status code, padding stays zero
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != STATUS_UNUSED && m_tdata[15:9] == 7'd0)
        else $error("bad status code or padding");

endmodule

bind unordered_key_list ukl_checker u_ukl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
